// ===== hdl/srr_pkg.sv =====
`default_nettype none

package srr_pkg;

   localparam int SEQ_W = 4;
   localparam int BYTES_W = 7;

   localparam int SEQ_SPACE_DEF = 16;
   localparam int WINDOW_SIZE = 8;
   localparam int PACKET_BYTES = 64;

   localparam logic KIND_ACK = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq_number;
      logic               final_packet;
      logic [BYTES_W-1:0] packet_bytes;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [SEQ_W-1:0]   slot_number;
      logic [BYTES_W-1:0] delivered_bytes;
      logic               transfer_done;
      logic               run_end;
   } rsp_type;

   // Load request from the sequencer into the output register.
   typedef struct packed {
      logic    load;
      rsp_type data;
   } rsp_ctl_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DELIVER
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/srr_rsp_reg.sv =====
`default_nettype none

module srr_rsp_reg
   import srr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rsp_ctl_type ctl,
   output logic             free,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // A new item may be loaded when the register is empty or its item leaves now.
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= ctl.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== hdl/selective_repeat_receiver_unit.sv =====
`default_nettype none
// Channel   Ports                           Direction  Item
// request   req_valid req_stall req_data    in         one arriving data packet
// response  rsp_valid rsp_stall rsp_data    out        acknowledgement or delivery
//
// After reset a clearing pass writes every receive mark, with req_stall high.
// A packet is taken only when the sequencer is idle; its mark is read from the mark RAM
// and the acknowledgement is loaded in the check state once the output register is free.
// The input stays stalled until the acknowledgement and any deliveries are loaded.
// Each delivery uses the RAM to clear one slot and read the next.
// Stalls on the response side hold the sequencer in the check and deliver states.

module selective_repeat_receiver_unit
   import srr_pkg::*;
#(
   parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int AW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
   localparam int EW = ((AW > SEQ_W) ? AW : SEQ_W) + 1;
   localparam int WIN = (WINDOW_SIZE < SEQ_SPACE) ? WINDOW_SIZE : SEQ_SPACE;
   localparam logic [EW-1:0] SPACE_E = EW'(SEQ_SPACE);
   localparam logic [EW-1:0] WIN_E = EW'(WIN);
   localparam logic [AW-1:0] LAST_SLOT = AW'(SEQ_SPACE - 1);
   localparam logic [BYTES_W-1:0] FULL_BYTES = BYTES_W'(PACKET_BYTES);

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
      logic [AW-1:0] r;
      if (s == LAST_SLOT) begin
         r = '0;
      end else begin
         r = s + AW'(1);
      end
      return r;
   endfunction

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [AW-1:0]      base_ff, base_in;
   logic               finished_ff, finished_in;
   logic               final_seen_ff, final_seen_in;
   logic [AW-1:0]      final_slot_ff, final_slot_in;
   logic [BYTES_W-1:0] final_bytes_ff, final_bytes_in;
   req_type            req_ff, req_in;

   logic          mark_mem [SEQ_SPACE];
   logic          rd_mark_ff;
   logic          mem_we, mem_wdata, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;

   rsp_ctl_type rsp_ctl;
   logic        rsp_free;

   logic [EW-1:0] seq_e, base_e, sum_e, offset_e;
   logic [AW-1:0] seq_idx, base_next, base_next2;
   logic          in_range, pkt_ok, at_base, done;

   assign seq_e      = EW'(req_ff.seq_number);
   assign base_e     = EW'(base_ff);
   assign seq_idx    = seq_e[AW-1:0];
   assign in_range   = seq_e < SPACE_E;
   assign sum_e      = seq_e + SPACE_E - base_e;
   assign offset_e   = (sum_e >= SPACE_E) ? (sum_e - SPACE_E) : sum_e;
   assign pkt_ok     = in_range && (offset_e < WIN_E) && !rd_mark_ff;
   assign at_base    = (seq_e == base_e);
   assign base_next  = next_slot(base_ff);
   assign base_next2 = next_slot(base_next);
   assign done       = final_seen_ff && (base_ff == final_slot_ff);

   // The slot at the base is never marked between items, so a delivery follows
   // the acknowledgement exactly when the new packet lands on the base.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      base_in        = base_ff;
      finished_in    = finished_ff;
      final_seen_in  = final_seen_ff;
      final_slot_in  = final_slot_ff;
      final_bytes_in = final_bytes_ff;
      req_in         = req_ff;
      mem_we         = 1'b0;
      mem_wdata      = 1'b0;
      mem_waddr      = base_ff;
      mem_re         = 1'b0;
      mem_raddr      = base_next;
      rsp_ctl        = '0;
      req_stall      = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && !finished_ff) begin
               req_in    = req_data;
               mem_re    = (EW'(req_data.seq_number) < SPACE_E);
               mem_raddr = AW'(EW'(req_data.seq_number));
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rsp_free) begin
               rsp_ctl.load                 = 1'b1;
               rsp_ctl.data.result_kind     = KIND_ACK;
               rsp_ctl.data.slot_number     = req_ff.seq_number;
               rsp_ctl.data.delivered_bytes = '0;
               rsp_ctl.data.transfer_done   = 1'b0;
               rsp_ctl.data.run_end         = !(pkt_ok && at_base);
               state_in                     = ST_IDLE;
               if (pkt_ok) begin
                  if (req_ff.final_packet) begin
                     final_seen_in = 1'b1;
                     final_slot_in = seq_idx;
                     if (32'(req_ff.packet_bytes) > 32'(PACKET_BYTES)) begin
                        final_bytes_in = FULL_BYTES;
                     end else begin
                        final_bytes_in = req_ff.packet_bytes;
                     end
                  end
                  if (at_base) begin
                     mem_re    = 1'b1;
                     mem_raddr = base_next;
                     state_in  = ST_DELIVER;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = 1'b1;
                     mem_waddr = seq_idx;
                  end
               end
            end
         end
         ST_DELIVER: begin
            // rd_mark_ff holds the mark of the slot after the base.
            if (rsp_free) begin
               rsp_ctl.load                 = 1'b1;
               rsp_ctl.data.result_kind     = KIND_DELIVER;
               rsp_ctl.data.slot_number     = base_e[SEQ_W-1:0];
               rsp_ctl.data.delivered_bytes = done ? final_bytes_ff : FULL_BYTES;
               rsp_ctl.data.transfer_done   = done;
               rsp_ctl.data.run_end         = done || !rd_mark_ff;
               mem_we                       = 1'b1;
               mem_wdata                    = 1'b0;
               mem_waddr                    = base_ff;
               base_in                      = base_next;
               if (done) begin
                  finished_in = 1'b1;
                  state_in    = ST_IDLE;
               end else if (rd_mark_ff) begin
                  mem_re    = 1'b1;
                  mem_raddr = base_next2;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         base_ff        <= '0;
         finished_ff    <= 1'b0;
         final_seen_ff  <= 1'b0;
         final_slot_ff  <= '0;
         final_bytes_ff <= '0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         base_ff        <= base_in;
         finished_ff    <= finished_in;
         final_seen_ff  <= final_seen_in;
         final_slot_ff  <= final_slot_in;
         final_bytes_ff <= final_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // Receive marks; the read data only changes on a read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mark_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_mark_ff <= mark_mem[mem_raddr];
      end
   end

   srr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rsp_ctl),
      .free      (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("mark RAM read and write hit the same slot in one cycle");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_ctl.load |-> rsp_free)
      else $error("result loaded while the output register is occupied");

   a_silent_after_done: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !rsp_ctl.load)
      else $error("result produced after the transfer finished");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_ctl.load && rsp_ctl.data.transfer_done) |=> finished_ff)
      else $error("final delivery did not finish the transfer");

   a_clear_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (req_stall && !rsp_ctl.load))
      else $error("activity during the clearing pass");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
   import srr_pkg::*;

   localparam int RX_WINDOW = (WINDOW_SIZE < SEQ_SPACE_DEF) ? WINDOW_SIZE : SEQ_SPACE_DEF;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 24;
   localparam int OPENING_ROWS = 22;
   localparam int NUM_ROWS = 32;
   localparam rsp_type NO_RSP = '0;

   typedef struct packed {
      logic       from_base;  // seq_number holds an offset from the window base
      req_type    pkt;
      logic       typed;
      logic [1:0] typed_count;
      rsp_type    first_rsp;
      rsp_type    second_rsp;
   } script_row_type;

   // Opening rows start from reset. Closing rows run after a flush that empties
   // the window, so most of their sequence numbers are taken relative to the base.
   localparam script_row_type SCRIPT [NUM_ROWS] = '{
      '{1'b0, '{4'd0, 1'b0, 7'd127}, 1'b1, 2'd2, '{KIND_ACK, 4'd0, 7'd0, 1'b0, 1'b0},
        '{KIND_DELIVER, 4'd0, 7'd64, 1'b0, 1'b1}},
      '{1'b0, '{4'd0, 1'b0, 7'd0}, 1'b1, 2'd1, '{KIND_ACK, 4'd0, 7'd0, 1'b0, 1'b1}, NO_RSP},
      '{1'b0, '{4'd15, 1'b1, 7'd127}, 1'b1, 2'd1, '{KIND_ACK, 4'd15, 7'd0, 1'b0, 1'b1}, NO_RSP},
      '{1'b0, '{4'd8, 1'b0, 7'd64}, 1'b1, 2'd1, '{KIND_ACK, 4'd8, 7'd0, 1'b0, 1'b1}, NO_RSP},
      '{1'b0, '{4'd8, 1'b1, 7'd65}, 1'b1, 2'd1, '{KIND_ACK, 4'd8, 7'd0, 1'b0, 1'b1}, NO_RSP},
      '{1'b0, '{4'd9, 1'b0, 7'd1}, 1'b1, 2'd1, '{KIND_ACK, 4'd9, 7'd0, 1'b0, 1'b1}, NO_RSP},
      '{1'b0, '{4'd3, 1'b0, 7'd42}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd5, 1'b0, 7'd85}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd4, 1'b0, 7'd21}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd7, 1'b0, 7'd106}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd6, 1'b0, 7'd63}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd2, 1'b0, 7'd0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd1, 1'b0, 7'd127}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd9, 1'b0, 7'd0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd11, 1'b0, 7'd10}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd12, 1'b0, 7'd100}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd13, 1'b0, 7'd50}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd14, 1'b0, 7'd77}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd10, 1'b0, 7'd3}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd15, 1'b0, 7'd120}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd1, 1'b0, 7'd31}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd0, 1'b0, 7'd96}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b1, '{4'd5, 1'b1, 7'd20}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b1, '{4'd3, 1'b1, 7'd100}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b1, '{4'd6, 1'b0, 7'd7}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b1, '{4'd1, 1'b0, 7'd33}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b1, '{4'd4, 1'b0, 7'd99}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b1, '{4'd2, 1'b0, 7'd64}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b1, '{4'd0, 1'b0, 7'd12}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd0, 1'b1, 7'd127}, 1'b1, 2'd0, NO_RSP, NO_RSP},
      '{1'b0, '{4'd15, 1'b0, 7'd0}, 1'b1, 2'd0, NO_RSP, NO_RSP},
      '{1'b1, '{4'd6, 1'b1, 7'd64}, 1'b1, 2'd0, NO_RSP, NO_RSP}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predictor state of the receive window.
   bit               rx_marks [SEQ_SPACE_DEF];
   logic [SEQ_W-1:0] win_base = '0;
   logic             fin_seen = 1'b0;
   logic [SEQ_W-1:0] fin_slot = '0;
   logic [BYTES_W-1:0] fin_bytes = '0;
   logic             transfer_over = 1'b0;

   rsp_type awaited_results [$];
   rsp_type predicted [$];
   rsp_type want;

   logic    typed_active = 1'b0;
   int      typed_count = 0;
   rsp_type typed_first = '0;
   rsp_type typed_second = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int packets_sent = 0;
   int results_checked = 0;
   int deliveries_checked = 0;
   int quiet_cycles = 0;

   selective_repeat_receiver_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [SEQ_W-1:0] slot_at(input int offset);
      return SEQ_W'((int'(win_base) + offset) % SEQ_SPACE_DEF);
   endfunction

   function automatic logic packet_dropped(input logic [SEQ_W-1:0] seq);
      int offset;
      offset = (int'(seq) + SEQ_SPACE_DEF - int'(win_base)) % SEQ_SPACE_DEF;
      return (int'(seq) >= SEQ_SPACE_DEF) || (offset >= RX_WINDOW) || rx_marks[seq];
   endfunction

   function automatic void receive_packet(input req_type pkt, ref rsp_type results [$]);
      rsp_type held;
      results = {};
      if (transfer_over)
         return;
      held = '0;
      held.result_kind = KIND_ACK;
      held.slot_number = pkt.seq_number;
      held.run_end = 1'b1;
      if (!packet_dropped(pkt.seq_number)) begin
         rx_marks[pkt.seq_number] = 1'b1;
         if (pkt.final_packet) begin
            fin_seen = 1'b1;
            fin_slot = pkt.seq_number;
            fin_bytes = (pkt.packet_bytes > PACKET_BYTES) ? BYTES_W'(PACKET_BYTES)
                                                          : pkt.packet_bytes;
         end
         for (int n = 0; n < RX_WINDOW; n++) begin
            if (!rx_marks[win_base])
               break;
            rx_marks[win_base] = 1'b0;
            held.run_end = 1'b0;
            results.push_back(held);
            held = '0;
            held.result_kind = KIND_DELIVER;
            held.slot_number = win_base;
            held.transfer_done = fin_seen && (win_base == fin_slot);
            held.delivered_bytes = held.transfer_done ? fin_bytes : BYTES_W'(PACKET_BYTES);
            held.run_end = 1'b1;
            win_base = slot_at(1);
            if (held.transfer_done) begin
               transfer_over = 1'b1;
               break;
            end
         end
      end
      results.push_back(held);
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < 50)
         $display("MISMATCH: %s", msg);
      error_count++;
   endtask

   // Called just after a falling edge; returns just after the falling edge that
   // follows the acceptance of the item.
   task automatic send_packet(input req_type pkt, input logic use_typed, input int n_typed,
                              input rsp_type rsp_a, input rsp_type rsp_b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= pkt;
      typed_active = use_typed;
      typed_count = n_typed;
      typed_first = rsp_a;
      typed_second = rsp_b;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   task automatic run_rows(input int first, input int stop);
      req_type pkt;
      for (int i = first; i < stop; i++) begin
         pkt = SCRIPT[i].pkt;
         if (SCRIPT[i].from_base)
            pkt.seq_number = slot_at(int'(SCRIPT[i].pkt.seq_number));
         send_packet(pkt, SCRIPT[i].typed, int'(SCRIPT[i].typed_count),
                     SCRIPT[i].first_rsp, SCRIPT[i].second_rsp);
      end
   endtask

   // Mostly packets inside the window with the base arriving often enough to
   // slide it; the rest land anywhere; only dropped ones may be marked final.
   task automatic random_packets(input int count);
      req_type pkt;
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         pkt.packet_bytes = BYTES_W'($urandom_range(0, 127));
         pkt.final_packet = 1'b0;
         if (pick < 55) begin
            pkt.seq_number = slot_at($urandom_range(1, RX_WINDOW - 1));
         end else if (pick < 75) begin
            pkt.seq_number = win_base;
         end else begin
            pkt.seq_number = SEQ_W'($urandom_range(0, SEQ_SPACE_DEF - 1));
            if (packet_dropped(pkt.seq_number))
               pkt.final_packet = 1'($urandom_range(0, 1));
         end
         send_packet(pkt, 1'b0, 0, NO_RSP, NO_RSP);
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            receive_packet(req_data, predicted);
            if (typed_active) begin
               predicted = {};
               if (typed_count > 0)
                  predicted.push_back(typed_first);
               if (typed_count > 1)
                  predicted.push_back(typed_second);
            end
            foreach (predicted[i])
               awaited_results.push_back(predicted[i]);
            packets_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result without expectation: kind %0d slot %0d",
                                         rsp_data.result_kind, rsp_data.slot_number));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.result_kind !== want.result_kind)
                  report_mismatch($sformatf("result %0d kind got %0d want %0d",
                     results_checked, rsp_data.result_kind, want.result_kind));
               if (rsp_data.slot_number !== want.slot_number)
                  report_mismatch($sformatf("result %0d slot got %0d want %0d",
                     results_checked, rsp_data.slot_number, want.slot_number));
               if (rsp_data.delivered_bytes !== want.delivered_bytes)
                  report_mismatch($sformatf("result %0d bytes got %0d want %0d",
                     results_checked, rsp_data.delivered_bytes, want.delivered_bytes));
               if (rsp_data.transfer_done !== want.transfer_done)
                  report_mismatch($sformatf("result %0d done got %0d want %0d",
                     results_checked, rsp_data.transfer_done, want.transfer_done));
               if (rsp_data.run_end !== want.run_end)
                  report_mismatch($sformatf("result %0d run end got %0d want %0d",
                     results_checked, rsp_data.run_end, want.run_end));
               if (want.result_kind == KIND_DELIVER)
                  deliveries_checked++;
            end
            results_checked++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timed out after %0d cycles without an item moving.", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 12;
      recv_idle_pct = 72;
      run_rows(0, OPENING_ROWS);
      random_packets(60);

      send_idle_pct = 72;
      recv_idle_pct = 12;
      random_packets(60);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_packets(60);

      // Fill the whole window, base last, so that it slides clean before the
      // final packets go in.
      for (int k = 1; k <= RX_WINDOW; k++)
         send_packet('{slot_at(k % RX_WINDOW), 1'b0, BYTES_W'($urandom_range(0, 127))},
                     1'b0, 0, NO_RSP, NO_RSP);
      run_rows(OPENING_ROWS, NUM_ROWS);
      req_valid <= 1'b0;

      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d packets; checked %0d results, %0d of them in-order deliveries.",
               packets_sent, results_checked, deliveries_checked);
      $display("Window base ended at slot %0d with the transfer %s.", win_base,
               transfer_over ? "finished" : "still open");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/srr_pkg.sv
hdl/srr_rsp_reg.sv
hdl/selective_repeat_receiver_unit.sv
tb/testbench.sv
